// ----- rtl/slt_pkg.sv -----
// slt_pkg: shared types and constants for the sequential list table
// holds request and status codes, field widths, the fsm state type and the cell control struct
// no dependencies
package slt_pkg;

    // field widths
    localparam int REQ_W    = 2;
    localparam int POS_W    = 10;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int LEN_W    = 11;

    // stream payload widths, packed and padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // default table depth and match bits examined per scan cycle
    localparam int DEPTH_DEFAULT = 1024;
    localparam int SCAN_GROUP    = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // shift up from position, load value at position
        logic del;   // shift down from position
        logic cmp;   // capture match bit against value
        logic scan;  // move match bits down by one scan group
    } cell_ctrl_t;

endpackage

// ----- rtl/slt_cell.sv -----
// slt_cell: one entry of the table, with its neighbor links and a match flag
// depends on slt_pkg for the control struct and value width
module slt_cell #(
    parameter int KW  = 11,
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slt_pkg::cell_ctrl_t               ctrl,
    input  logic [KW-1:0]                     pos,
    input  logic [KW-1:0]                     count,
    input  logic signed [slt_pkg::VAL_W-1:0]  value,
    input  logic signed [slt_pkg::VAL_W-1:0]  lower_data,
    input  logic signed [slt_pkg::VAL_W-1:0]  upper_data,
    input  logic                              match_in,
    output logic signed [slt_pkg::VAL_W-1:0]  data,
    output logic                              match
);
    import slt_pkg::*;

    localparam logic [KW-1:0] IDX_K = KW'(IDX);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    match_reg;
    logic                    match_next;

    // entry update: open a gap on insert, close it on delete
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (IDX_K > pos)
                entry_next = lower_data;
            else if (IDX_K == pos)
                entry_next = value;
        end
        else if (ctrl.del)
        begin
            if (IDX_K >= pos)
                entry_next = upper_data;
        end
    end

    // match flag: compare against occupied entries, then shift toward cell 0
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp)
            match_next = (entry_reg == value) && (IDX_K < count);
        else if (ctrl.scan)
            match_next = match_in;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign data  = entry_reg;
    assign match = match_reg;

endmodule

// ----- rtl/slt_scan.sv -----
// slt_scan: priority encoder over the match flags of the lowest scan group
// no package dependencies, sized by its parameters
module slt_scan #(
    parameter int G  = 32,
    parameter int GW = 5
) (
    input  logic [G-1:0]  match,
    output logic          hit,
    output logic [GW-1:0] offset
);

    // lowest set flag wins
    always_comb
    begin
        offset = '0;
        for (int i = G - 1; i >= 0; i--)
        begin
            if (match[i])
                offset = GW'(i);
        end
    end

    assign hit = |match;

endmodule

// ----- rtl/sequential_list_table.sv -----
// sequential_list_table: packed ordered table of signed 32-bit entries in a row of cells
// insert, delete or invalid request: result loaded into the result register on the transaction
// find: match flags captured on the transaction, then moved 32 cells toward cell 0 per cycle
//   past one priority encoder; result registered at the first hit or once the scan passes the length
// a request is taken each cycle while idle and the result register is free or draining
// reset: length and match flags clear at once; entries are not reset
module sequential_list_table #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [slt_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
    input  logic [slt_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] position, [41:10] value, rest zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [slt_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic [slt_pkg::M_TDATA_W-1:0]  m_tdata    // [9:0] found_index, [20:10] length
);
    import slt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > POS_W) ? CW : POS_W;
    localparam int G  = (DEPTH < SCAN_GROUP) ? DEPTH : SCAN_GROUP;
    localparam int GW = $clog2(G);
    localparam int NG = (DEPTH + G - 1) / G;
    localparam int BW = $clog2(NG * G + 1) + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t                  state_reg;
    state_t                  state_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [BW-1:0]           base_reg;
    logic [BW-1:0]           base_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic [INDEX_W-1:0]      index_reg;
    logic [INDEX_W-1:0]      index_next;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;

    logic                    accept;
    logic [REQ_W-1:0]        req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [KW-1:0]           pos_ext;
    logic [KW-1:0]           count_ext;
    logic [BW-1:0]           group_end;
    logic                    scan_hit;
    logic [GW-1:0]           scan_offset;
    logic                    scan_done;
    logic                    out_load;
    cell_ctrl_t              ctrl;

    logic signed [VAL_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]        match;

    // request fields
    assign req_type  = s_tuser;
    assign position  = s_tdata[POS_W-1:0];
    assign value     = signed'(s_tdata[POS_W+VAL_W-1:POS_W]);
    assign pos_ext   = KW'(position);
    assign count_ext = KW'(count_reg);

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // scan of the lowest group of match flags
    slt_scan #(
        .G  (G),
        .GW (GW)
    ) u_scan (
        .match  (match[G-1:0]),
        .hit    (scan_hit),
        .offset (scan_offset)
    );

    assign group_end = base_reg + BW'(G);
    assign scan_done = scan_hit || (group_end >= BW'(count_reg));

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] upper;
        logic                    match_up;

        if (i == 0)
        begin : g_bottom
            assign lower = value;
        end
        else
        begin : g_lower
            assign lower = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign upper = cell_data[i];
        end
        else
        begin : g_upper
            assign upper = cell_data[i+1];
        end

        if (i + G < DEPTH)
        begin : g_feed
            assign match_up = match[i+G];
        end
        else
        begin : g_nofeed
            assign match_up = 1'b0;
        end

        slt_cell #(
            .KW  (KW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .pos        (pos_ext),
            .count      (count_ext),
            .value      (value),
            .lower_data (lower),
            .upper_data (upper),
            .match_in   (match_up),
            .data       (cell_data[i]),
            .match      (match[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_FIND))
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // request decode, cell commands and result
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        base_next   = base_reg;
        out_load    = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    base_next = '0;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            out_load   = 1'b1;
                            index_next = '0;
                            if (count_reg == FULL_COUNT)
                                status_next = ST_FULL;
                            else if (pos_ext > count_ext)
                                status_next = ST_BAD_POS;
                            else
                            begin
                                status_next = ST_OK;
                                ctrl.ins    = 1'b1;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            out_load   = 1'b1;
                            index_next = '0;
                            if (pos_ext >= count_ext)
                                status_next = ST_BAD_POS;
                            else
                            begin
                                status_next = ST_OK;
                                ctrl.del    = 1'b1;
                                count_next  = count_reg - CW'(1);
                            end
                        end
                        REQ_FIND:
                            ctrl.cmp = 1'b1;
                        default:
                        begin
                            out_load    = 1'b1;
                            status_next = ST_OK;
                            index_next  = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    out_load    = 1'b1;
                    status_next = ST_OK;
                    index_next  = INDEX_W'(base_reg + BW'(scan_offset));
                end
                else if (scan_done)
                begin
                    out_load    = 1'b1;
                    status_next = ST_NOT_FOUND;
                    index_next  = '0;
                end
                else
                begin
                    ctrl.scan = 1'b1;
                    base_next = group_end;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // result register
    assign len_next      = out_load ? LEN_W'(count_next) : len_reg;
    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            base_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            base_reg     <= base_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
        len_reg    <= len_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - LEN_W - INDEX_W){1'b0}}, len_reg, index_reg};

endmodule

// ----- rtl/slt_checker.sv -----
// slt_checker: port-level assertions for sequential_list_table, bound to the top level
// depends on slt_pkg for codes and widths
module slt_checker #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [slt_pkg::REQ_W-1:0]      s_tuser,
    input logic [slt_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [slt_pkg::STATUS_W-1:0]   m_tuser,
    input logic [slt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import slt_pkg::*;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

    logic [INDEX_W-1:0] found_index;
    logic [LEN_W-1:0]   length;

    assign found_index = m_tdata[INDEX_W-1:0];
    assign length      = m_tdata[INDEX_W+LEN_W-1:INDEX_W];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata))
        else $error("result changed while stalled");

    // a full table reports its full length
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> length == FULL_LEN)
        else $error("full status with wrong length");

    // a failed request carries a zero index
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> found_index == '0)
        else $error("nonzero index on failed request");

    // length never passes the depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 2048) |-> length <= FULL_LEN)
        else $error("length beyond depth");

endmodule

bind sequential_list_table slt_checker #(.DEPTH(DEPTH)) u_slt_checker (.*);

// ----- tb/sequential_list_table_checker.sv -----
`timescale 1ns / 100ps
// sequential_list_table_checker: watches both stream channels, predicts each reply from a shadow
// list and compares it field by field, counting failures for the testbench top
// depends on slt_pkg
module sequential_list_table_checker #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [slt_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
    input  logic [slt_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] position, [41:10] value, rest zero
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [slt_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    input  logic [slt_pkg::M_TDATA_W-1:0]  m_tdata,   // [9:0] found_index, [20:10] length
    output int                             fail_count,
    output int                             pending_count
);
    import slt_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  found_index;
        logic [LEN_W-1:0]    length;
    } list_reply_t;

    // shadow copy of the list contents and its length
    logic [VAL_W-1:0] shadow_entries [DEPTH];
    int unsigned      shadow_len;
    list_reply_t      reply_queue [$];
    list_reply_t      want_reply;
    list_reply_t      got_reply;

    // apply one request to the shadow list and return the reply it should give
    function automatic list_reply_t predict_reply(input logic [REQ_W-1:0] kind,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [VAL_W-1:0] val);
        list_reply_t r;
        int unsigned slot;
        int unsigned i;
        bit          hit;
        slot          = pos;
        hit           = 1'b0;
        r.status      = ST_OK;
        r.found_index = '0;
        case (kind)
            REQ_INSERT:
            begin
                if (shadow_len >= DEPTH)
                    r.status = ST_FULL;
                else if (slot > shadow_len)
                    r.status = ST_BAD_POS;
                else
                begin
                    for (i = shadow_len; i > slot; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[slot] = val;
                    shadow_len++;
                end
            end
            REQ_DELETE:
            begin
                if (slot >= shadow_len)
                    r.status = ST_BAD_POS;
                else
                begin
                    for (i = slot; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                end
            end
            REQ_FIND:
            begin
                // lowest matching index wins
                for (i = 0; i < shadow_len && !hit; i++)
                begin
                    if (shadow_entries[i] == val)
                    begin
                        hit           = 1'b1;
                        r.found_index = INDEX_W'(i);
                    end
                end
                if (!hit)
                    r.status = ST_NOT_FOUND;
            end
            default:
                r.status = ST_OK;
        endcase
        r.length = LEN_W'(shadow_len);
        return r;
    endfunction

    // predict on each request transaction, compare on each reply transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len    = 0;
            reply_queue.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                reply_queue.push_back(predict_reply(s_tuser, s_tdata[POS_W-1:0],
                                                    s_tdata[POS_W+VAL_W-1:POS_W]));
            if (m_tvalid && m_tready)
            begin
                got_reply.status      = m_tuser;
                got_reply.found_index = m_tdata[INDEX_W-1:0];
                got_reply.length      = m_tdata[INDEX_W+LEN_W-1:INDEX_W];
                if (reply_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: reply with none pending: status %0d index %0d length %0d",
                                 $realtime, got_reply.status, got_reply.found_index,
                                 got_reply.length);
                    fail_count++;
                end
                else
                begin
                    want_reply = reply_queue.pop_front();
                    if (got_reply.status !== want_reply.status
                        || got_reply.found_index !== want_reply.found_index
                        || got_reply.length !== want_reply.length)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: reply mismatch: expected status %0d index %0d ",
                                      "length %0d, got status %0d index %0d length %0d"},
                                     $realtime, want_reply.status, want_reply.found_index,
                                     want_reply.length, got_reply.status,
                                     got_reply.found_index, got_reply.length);
                        fail_count++;
                    end
                end
            end
            pending_count = reply_queue.size();
        end
    end

endmodule

// ----- tb/sequential_list_table_test.sv -----
`timescale 1ns / 100ps
// sequential_list_table_test: drives insert, delete and find requests into the list table,
// filling it to capacity and shrinking it again, with random idling and one long reply stall
// depends on slt_pkg, sequential_list_table and sequential_list_table_checker
module sequential_list_table_test;
    import slt_pkg::*;

    localparam int                TABLE_DEPTH = DEPTH_DEFAULT;
    localparam logic [REQ_W-1:0]  REQ_NONE    = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [REQ_W-1:0]      s_tuser;   // [1:0] req_type
    logic [S_TDATA_W-1:0]  s_tdata;   // [9:0] position, [41:10] value, rest zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [STATUS_W-1:0]   m_tuser;   // [1:0] status
    logic [M_TDATA_W-1:0]  m_tdata;   // [9:0] found_index, [20:10] length
    int                    fail_count;
    int                    pending_count;

    int                    sent_count;
    int unsigned           list_len;
    bit                    quiet;
    logic [VAL_W-1:0]      value_pool [16];
    int                    hold_left;
    bit                    held_once;

    sequential_list_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    sequential_list_table_checker #(
        .DEPTH(TABLE_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tuser       (m_tuser),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    // offer one request, with random gaps, and wait for its transaction
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        while (!quiet && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-POS_W-VAL_W){1'b0}}, val, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        // track the length so positions can be aimed inside the list
        if (kind == REQ_INSERT && list_len < TABLE_DEPTH && pos <= list_len)
            list_len++;
        else if (kind == REQ_DELETE && pos < list_len)
            list_len--;
    endtask

    // mostly values already in the pool, so finds hit and duplicates build up
    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 75)
            return value_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] insert_slot();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3)
            return POS_W'(list_len);
        if (r < 5)
            return '0;
        return POS_W'($urandom_range(list_len));
    endfunction

    function automatic logic [POS_W-1:0] delete_slot();
        if (list_len == 0)
            return POS_W'($urandom);
        if ($urandom_range(9) < 2)
            return POS_W'(list_len - 1);
        return POS_W'($urandom_range(list_len - 1));
    endfunction

    // reply side: random stalls plus one long hold-off while requests keep coming
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        held_once = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held_once && sent_count >= 250)
            begin
                held_once = 1'b1;
                hold_left = 200;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(99) >= 21);
        end
    end

    // request stimulus and verdict
    initial
    begin
        int unsigned roll;
        int          n;
        s_tvalid   = 1'b0;
        s_tuser    = '0;
        s_tdata    = '0;
        rst_n      = 1'b0;
        sent_count = 0;
        list_len   = 0;
        quiet      = 1'b0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (n = 5; n < 16; n++)
            value_pool[n] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list corner cases
        send_request(REQ_FIND,   10'd0,    32'h0000_0000);
        send_request(REQ_DELETE, 10'd0,    32'h0000_0000);
        send_request(REQ_DELETE, 10'd1023, 32'hffff_ffff);
        send_request(REQ_INSERT, 10'd1,    32'h1234_5678);
        // directed: append, insert at front and middle, duplicates
        send_request(REQ_INSERT, 10'd0,    32'h8000_0000);
        send_request(REQ_INSERT, 10'd1,    32'h7fff_ffff);
        send_request(REQ_INSERT, 10'd0,    32'h0000_0000);
        send_request(REQ_INSERT, 10'd1,    32'hffff_ffff);
        send_request(REQ_INSERT, 10'd2,    32'hffff_ffff);
        send_request(REQ_FIND,   10'd1023, 32'hffff_ffff);
        send_request(REQ_FIND,   10'd0,    32'h8000_0000);
        send_request(REQ_FIND,   10'd0,    32'h7fff_ffff);
        send_request(REQ_FIND,   10'd0,    32'h0bad_cafe);
        // directed: positions past the end, deletes at both ends, unused type
        send_request(REQ_INSERT, 10'd1023, 32'h5555_5555);
        send_request(REQ_INSERT, 10'd6,    32'haaaa_aaaa);
        send_request(REQ_DELETE, 10'd0,    32'h0000_0000);
        send_request(REQ_DELETE, 10'd3,    32'h0000_0000);
        send_request(REQ_DELETE, 10'd4,    32'h0000_0000);
        send_request(REQ_NONE,   10'd1023, 32'hffff_ffff);
        send_request(REQ_NONE,   10'd0,    32'h0000_0000);
        send_request(REQ_FIND,   10'd0,    32'hffff_ffff);
        send_request(REQ_INSERT, 10'd3,    32'hffff_ffff);

        // climb to a full list with mostly well-formed inserts
        while (list_len < TABLE_DEPTH && sent_count < 1700)
        begin
            quiet = (sent_count >= 450 && sent_count < 650);
            roll  = $urandom_range(99);
            if (roll < 90)
                send_request(REQ_INSERT, insert_slot(), pick_value());
            else if (roll < 95)
                send_request(REQ_FIND, POS_W'($urandom), pick_value());
            else if (roll < 97)
                send_request(REQ_DELETE, delete_slot(), $urandom);
            else if (roll < 99)
                send_request(REQ_INSERT, POS_W'($urandom), $urandom);
            else
                send_request(REQ_NONE, POS_W'($urandom), $urandom);
        end
        quiet = 1'b0;

        // hammer the full list, with the odd delete reopening one slot
        for (n = 0; n < 40; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                send_request(REQ_INSERT, POS_W'($urandom), pick_value());
            else if (roll < 90)
                send_request(REQ_FIND, POS_W'($urandom), pick_value());
            else
                send_request(REQ_DELETE, delete_slot(), $urandom);
        end

        // mixed traffic that shrinks the list
        for (n = 0; n < 100; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                send_request(REQ_DELETE, delete_slot(), $urandom);
            else if (roll < 70)
                send_request(REQ_INSERT, insert_slot(), pick_value());
            else if (roll < 95)
                send_request(REQ_FIND, POS_W'($urandom), pick_value());
            else
                send_request(REQ_NONE, POS_W'($urandom), $urandom);
        end
        s_tvalid <= 1'b0;

        // drain outstanding replies, then allow for a full find scan
        @(posedge clk);
        wait (pending_count == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
